// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty when building for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define EPT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define EPT_NEVER(label, clk, rst_n, expr) \
    `EPT_ASSERT(label, clk, rst_n, !(expr))

`else

`define EPT_ASSERT(label, clk, rst_n, prop)
`define EPT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== design/ept_pkg.sv =====
// ---------------------------------------------------------------------------
// ept_pkg
// shared constants, types and the arctangent table for the ellipse generator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ept_pkg;

    // rotation stage count and angle precision
    localparam int CORDIC_STAGES = 24;
    localparam int ANGLE_BITS    = 32;

    // fixed field widths
    localparam int ANGLE_W     = 32;
    localparam int COORD_W     = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int CORDIC_W    = 34;
    localparam int TRIG_W      = 32;
    localparam int PROD_W      = 64;
    localparam int TERM_W      = 34;
    localparam int SUM_W       = 35;

    // low angle bits dropped to the configured precision
    localparam int ANGLE_DROP = ANGLE_W - ANGLE_BITS;
    localparam logic [ANGLE_W-1:0] ANGLE_MASK =
        ~((32'd1 << ANGLE_DROP) - 32'd1);

    // cordic start vector and trig limit, q1.30
    localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ONE_Q30  = 34'sd1073741824;

    // rounding offset for q16.16 times q1.30
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd536870912;

    // saturation limits
    localparam logic signed [SUM_W-1:0] COORD_MAX = 35'sd2147483647;
    localparam logic signed [SUM_W-1:0] COORD_MIN = -35'sd2147483648;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_X = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_Y = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 4'd3;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RADIUS_RESET = 32'd65536;
    localparam logic [CFG_DATA_W-1:0] CENTER_RESET = 32'd0;

    // stage index selects a shift and a table entry
    typedef logic [4:0] stage_idx_t;

    // arctangent of 2^-i as a fraction of a full turn
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // one item in flight through the rotation stages
    typedef struct packed {
        logic                       req;
        logic                       flip;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } cordic_item_t;

endpackage

// ===== design/ept_cordic_stage.sv =====
// ---------------------------------------------------------------------------
// ept_cordic_stage
// one registered rotation-mode cordic micro-rotation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ept_cordic_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  ept_pkg::cordic_item_t in_item,
    input  ept_pkg::stage_idx_t   stage_idx,
    output logic                  out_valid,
    output ept_pkg::cordic_item_t out_item
);

    logic                  valid_reg;
    ept_pkg::cordic_item_t item_reg;
    ept_pkg::cordic_item_t item_next;

    // rotate toward zero residual angle
    always_comb
    begin
        logic signed [ept_pkg::CORDIC_W-1:0] dx;
        logic signed [ept_pkg::CORDIC_W-1:0] dy;
        logic signed [ept_pkg::CORDIC_W-1:0] da;
        dx = $signed(in_item.y) >>> stage_idx;
        dy = $signed(in_item.x) >>> stage_idx;
        da = $signed({2'b00, ept_pkg::ATAN_TURNS[stage_idx]});
        item_next = in_item;
        if (!in_item.z[ept_pkg::CORDIC_W-1])
        begin
            item_next.x = in_item.x - dx;
            item_next.y = in_item.y + dy;
            item_next.z = in_item.z - da;
        end
        else
        begin
            item_next.x = in_item.x + dx;
            item_next.y = in_item.y - dy;
            item_next.z = in_item.z + da;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== design/ellipse_point_and_tangent_top.sv =====
// ---------------------------------------------------------------------------
// ellipse_point_and_tangent_top
// ellipse point / tangent generator with a pipelined cordic
// ---------------------------------------------------------------------------
// Accepts one angle per clock and returns one result per clock while the
// skid register is empty. An angle passes one angle fold stage, one
// register per cordic micro-rotation, then trig clamp, multiply, round and
// saturate stages. The rate is set by the fully unrolled cordic chain and
// the single 33x32 multiplier stage per axis. A skid register at the output
// lets one result wait while the pipeline keeps moving; the whole pipeline
// holds only when that skid register is full. Configuration writes take
// effect at once and are expected only while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ellipse_point_and_tangent_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ept_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ept_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [ept_pkg::ANGLE_W-1:0]        angle,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ept_pkg::COORD_W-1:0] coord_x,
    output logic signed [ept_pkg::COORD_W-1:0] coord_y,
    output logic                               overflow
);

    localparam int N = ept_pkg::CORDIC_STAGES;

    // configuration registers
    logic [ept_pkg::CFG_DATA_W-1:0] radius_x_reg;
    logic [ept_pkg::CFG_DATA_W-1:0] radius_y_reg;
    logic [ept_pkg::CFG_DATA_W-1:0] center_x_reg;
    logic [ept_pkg::CFG_DATA_W-1:0] center_y_reg;

    // pipeline enable, held only while the skid register is full
    logic pipe_en;

    // fold stage
    logic                  pre_valid_reg;
    ept_pkg::cordic_item_t pre_item_reg;
    ept_pkg::cordic_item_t pre_item_next;

    // rotation chain
    logic [N:0]            cordic_valid;
    ept_pkg::cordic_item_t cordic_item [0:N];

    // trig stage
    logic                                     f_valid_reg;
    logic                                     f_req_reg;
    logic signed [ept_pkg::TRIG_W-1:0]        f_trig_x_reg;
    logic signed [ept_pkg::TRIG_W-1:0]        f_trig_y_reg;
    logic signed [ept_pkg::TRIG_W-1:0]        f_trig_x_next;
    logic signed [ept_pkg::TRIG_W-1:0]        f_trig_y_next;

    // multiply stage
    logic                                     m_valid_reg;
    logic                                     m_req_reg;
    logic signed [ept_pkg::PROD_W-1:0]        m_prod_x_reg;
    logic signed [ept_pkg::PROD_W-1:0]        m_prod_y_reg;
    logic signed [ept_pkg::PROD_W:0]          m_prod_x_next;
    logic signed [ept_pkg::PROD_W:0]          m_prod_y_next;

    // round stage
    logic                                     r_valid_reg;
    logic                                     r_req_reg;
    logic signed [ept_pkg::TERM_W-1:0]        r_term_x_reg;
    logic signed [ept_pkg::TERM_W-1:0]        r_term_y_reg;
    logic signed [ept_pkg::PROD_W-1:0]        r_round_x;
    logic signed [ept_pkg::PROD_W-1:0]        r_round_y;

    // saturate stage, also the output register
    logic                                     s_valid_reg;
    logic signed [ept_pkg::COORD_W-1:0]       s_x_reg;
    logic signed [ept_pkg::COORD_W-1:0]       s_y_reg;
    logic                                     s_ovf_reg;
    logic signed [ept_pkg::COORD_W-1:0]       s_x_next;
    logic signed [ept_pkg::COORD_W-1:0]       s_y_next;
    logic                                     s_ovf_next;

    // skid register
    logic                                     skid_valid_reg;
    logic signed [ept_pkg::COORD_W-1:0]       skid_x_reg;
    logic signed [ept_pkg::COORD_W-1:0]       skid_y_reg;
    logic                                     skid_ovf_reg;

    assign pipe_en  = !skid_valid_reg;
    assign in_ready = pipe_en;

    // configuration writes, unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_x_reg <= ept_pkg::RADIUS_RESET;
            radius_y_reg <= ept_pkg::RADIUS_RESET;
            center_x_reg <= ept_pkg::CENTER_RESET;
            center_y_reg <= ept_pkg::CENTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ept_pkg::REG_RADIUS_X: radius_x_reg <= cfg_data;
                ept_pkg::REG_RADIUS_Y: radius_y_reg <= cfg_data;
                ept_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                ept_pkg::REG_CENTER_Y: center_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // fold the angle into the right half plane
    always_comb
    begin
        logic [ept_pkg::ANGLE_W-1:0] am;
        logic                        flip;
        logic [ept_pkg::ANGLE_W-1:0] af;
        am   = angle & ept_pkg::ANGLE_MASK;
        flip = am[ept_pkg::ANGLE_W-1] ^ am[ept_pkg::ANGLE_W-2];
        af   = {am[ept_pkg::ANGLE_W-1] ^ flip, am[ept_pkg::ANGLE_W-2:0]};
        pre_item_next.req  = req_type;
        pre_item_next.flip = flip;
        pre_item_next.x    = ept_pkg::GAIN_Q30;
        pre_item_next.y    = '0;
        pre_item_next.z    = $signed({{2{af[ept_pkg::ANGLE_W-1]}}, af});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (pipe_en)
            pre_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            pre_item_reg <= pre_item_next;
    end

    // rotation chain, one register per micro-rotation
    assign cordic_valid[0] = pre_valid_reg;
    assign cordic_item[0]  = pre_item_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        ept_cordic_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (cordic_valid[i]),
            .in_item   (cordic_item[i]),
            .stage_idx (ept_pkg::stage_idx_t'(i)),
            .out_valid (cordic_valid[i+1]),
            .out_item  (cordic_item[i+1])
        );
    end

    // unfold, clamp and route cosine / sine to the axes
    always_comb
    begin
        logic signed [ept_pkg::CORDIC_W-1:0] cx;
        logic signed [ept_pkg::CORDIC_W-1:0] sy;
        logic signed [ept_pkg::CORDIC_W-1:0] cc;
        logic signed [ept_pkg::CORDIC_W-1:0] sc;
        cx = cordic_item[N].flip ? -cordic_item[N].x : cordic_item[N].x;
        sy = cordic_item[N].flip ? -cordic_item[N].y : cordic_item[N].y;
        cc = cx;
        if (cx > ept_pkg::ONE_Q30)
            cc = ept_pkg::ONE_Q30;
        else if (cx < -ept_pkg::ONE_Q30)
            cc = -ept_pkg::ONE_Q30;
        sc = sy;
        if (sy > ept_pkg::ONE_Q30)
            sc = ept_pkg::ONE_Q30;
        else if (sy < -ept_pkg::ONE_Q30)
            sc = -ept_pkg::ONE_Q30;
        if (cordic_item[N].req)
        begin
            f_trig_x_next = sc[ept_pkg::TRIG_W-1:0];
            f_trig_y_next = cc[ept_pkg::TRIG_W-1:0];
        end
        else
        begin
            f_trig_x_next = cc[ept_pkg::TRIG_W-1:0];
            f_trig_y_next = sc[ept_pkg::TRIG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (pipe_en)
            f_valid_reg <= cordic_valid[N];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            f_req_reg    <= cordic_item[N].req;
            f_trig_x_reg <= f_trig_x_next;
            f_trig_y_reg <= f_trig_y_next;
        end
    end

    // radius times trig, q16.16 by q1.30
    always_comb
    begin
        m_prod_x_next = $signed({1'b0, radius_x_reg}) * f_trig_x_reg;
        m_prod_y_next = $signed({1'b0, radius_y_reg}) * f_trig_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (pipe_en)
            m_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m_req_reg    <= f_req_reg;
            m_prod_x_reg <= m_prod_x_next[ept_pkg::PROD_W-1:0];
            m_prod_y_reg <= m_prod_y_next[ept_pkg::PROD_W-1:0];
        end
    end

    // round to q16.16 with floor shift
    assign r_round_x = (m_prod_x_reg + ept_pkg::ROUND_HALF) >>> 30;
    assign r_round_y = (m_prod_y_reg + ept_pkg::ROUND_HALF) >>> 30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid_reg <= 1'b0;
        else if (pipe_en)
            r_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            r_req_reg    <= m_req_reg;
            r_term_x_reg <= r_round_x[ept_pkg::TERM_W-1:0];
            r_term_y_reg <= r_round_y[ept_pkg::TERM_W-1:0];
        end
    end

    // negate or offset by the center, then saturate
    always_comb
    begin
        logic signed [ept_pkg::SUM_W-1:0] vx;
        logic signed [ept_pkg::SUM_W-1:0] vy;
        logic signed [ept_pkg::SUM_W-1:0] tx;
        logic signed [ept_pkg::SUM_W-1:0] ty;
        tx = ept_pkg::SUM_W'(r_term_x_reg);
        ty = ept_pkg::SUM_W'(r_term_y_reg);
        if (r_req_reg)
        begin
            vx = -tx;
            vy = ty;
        end
        else
        begin
            vx = tx + ept_pkg::SUM_W'($signed(center_x_reg));
            vy = ty + ept_pkg::SUM_W'($signed(center_y_reg));
        end
        s_ovf_next = 1'b0;
        s_x_next   = vx[ept_pkg::COORD_W-1:0];
        s_y_next   = vy[ept_pkg::COORD_W-1:0];
        if (vx > ept_pkg::COORD_MAX)
        begin
            s_x_next   = ept_pkg::COORD_MAX[ept_pkg::COORD_W-1:0];
            s_ovf_next = 1'b1;
        end
        else if (vx < ept_pkg::COORD_MIN)
        begin
            s_x_next   = ept_pkg::COORD_MIN[ept_pkg::COORD_W-1:0];
            s_ovf_next = 1'b1;
        end
        if (vy > ept_pkg::COORD_MAX)
        begin
            s_y_next   = ept_pkg::COORD_MAX[ept_pkg::COORD_W-1:0];
            s_ovf_next = 1'b1;
        end
        else if (vy < ept_pkg::COORD_MIN)
        begin
            s_y_next   = ept_pkg::COORD_MIN[ept_pkg::COORD_W-1:0];
            s_ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (pipe_en)
            s_valid_reg <= r_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s_x_reg   <= s_x_next;
            s_y_reg   <= s_y_next;
            s_ovf_reg <= s_ovf_next;
        end
    end

    // skid register catches a shown result that is about to be overwritten
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (s_valid_reg && !out_ready)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_x_reg   <= s_x_reg;
            skid_y_reg   <= s_y_reg;
            skid_ovf_reg <= s_ovf_reg;
        end
    end

    // result channel, older item first
    assign out_valid = skid_valid_reg || s_valid_reg;
    assign coord_x   = skid_valid_reg ? skid_x_reg   : s_x_reg;
    assign coord_y   = skid_valid_reg ? skid_y_reg   : s_y_reg;
    assign overflow  = skid_valid_reg ? skid_ovf_reg : s_ovf_reg;

    // assertions
    `EPT_ASSERT(a_out_valid_held, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
    `EPT_ASSERT(a_out_data_held, clk, rst_n, (out_valid && !out_ready) |=> $stable({coord_x, coord_y, overflow}))
    `EPT_ASSERT(a_accept_enters_pipe, clk, rst_n, (in_valid && in_ready) |=> pre_valid_reg)
    `EPT_ASSERT(a_overflow_at_limit, clk, rst_n, (out_valid && overflow) |-> (coord_x == 32'sh7FFFFFFF || coord_x == 32'sh80000000 || coord_y == 32'sh7FFFFFFF || coord_y == 32'sh80000000))

endmodule

// ===== tb/sv/ellipse_point_and_tangent_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ellipse_point_and_tangent_top_tb
// self-checking bench for the ellipse point / tangent generator
// ---------------------------------------------------------------------------
// A queue of angle requests feeds a clocked driver. Each accepted request is
// run through a bit-accurate cordic and scaling predictor, and the predicted
// coordinates wait in order for the clocked monitor, which checks every
// result field. The run walks through several register settings (reset
// values, radius and center extremes, zero radius, writes to unused indexes,
// random geometry), with random gaps on both sides, gap-free stretches and
// long output hold-offs that back the pipeline up into the request side.

module ellipse_point_and_tangent_top_tb;

    typedef enum logic
    {
        REQ_POINT   = 1'b0,
        REQ_TANGENT = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        req_kind_t                   kind;
        logic [ept_pkg::ANGLE_W-1:0] turn;
    } coord_req_t;

    typedef struct packed
    {
        logic signed [ept_pkg::COORD_W-1:0] x;
        logic signed [ept_pkg::COORD_W-1:0] y;
        logic                               ovf;
    } coord_result_t;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT_A    = 500;
    localparam int HOLD_AT_B    = 1300;
    localparam int DRAIN_CYCLES = ept_pkg::CORDIC_STAGES + 16;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // block ports
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [ept_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [ept_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    logic                               req_type  = 1'b0;
    logic [ept_pkg::ANGLE_W-1:0]        angle     = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [ept_pkg::COORD_W-1:0] coord_x;
    logic signed [ept_pkg::COORD_W-1:0] coord_y;
    logic                               overflow;

    // register shadow used by the predictor
    logic [ept_pkg::CFG_DATA_W-1:0]        semi_x;
    logic [ept_pkg::CFG_DATA_W-1:0]        semi_y;
    logic signed [ept_pkg::CFG_DATA_W-1:0] ctr_x;
    logic signed [ept_pkg::CFG_DATA_W-1:0] ctr_y;

    // request queue and coordinates still due
    coord_req_t    angle_reqs[$];
    coord_result_t coords_due[$];

    logic idle_on = 1'b1;
    int   send_gap;
    int   recv_wait;
    int   hold_left;
    int   recv_count;
    int   quiet_cycles;
    int   mismatch_count = 0;

    ellipse_point_and_tangent_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .overflow  (overflow)
    );

    // trig value limited to plus or minus one in q1.30
    function automatic longint clamp_unit(input longint v);
        if (v > longint'(ept_pkg::ONE_Q30))
            return longint'(ept_pkg::ONE_Q30);
        if (v < -longint'(ept_pkg::ONE_Q30))
            return -longint'(ept_pkg::ONE_Q30);
        return v;
    endfunction

    // q16.16 radius times q1.30 trig, rounded back to q16.16
    function automatic longint scale_radius(input logic [ept_pkg::CFG_DATA_W-1:0] r,
                                            input longint t);
        return (longint'({32'd0, r}) * t + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // clip to the signed coordinate range and flag it
    function automatic logic [ept_pkg::COORD_W-1:0] clip_coord(input longint v,
                                                               inout logic ovf);
        if (v > longint'(ept_pkg::COORD_MAX))
        begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < longint'(ept_pkg::COORD_MIN))
        begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[ept_pkg::COORD_W-1:0];
    endfunction

    // point or tangent for one angle under the current registers
    function automatic coord_result_t predict_coords(
        input req_kind_t                   kind,
        input logic [ept_pkg::ANGLE_W-1:0] turn);
        logic [ept_pkg::ANGLE_W-1:0] a;
        logic                        flip;
        logic                        ovf;
        longint                      x;
        longint                      y;
        longint                      z;
        longint                      dx;
        longint                      dy;
        longint                      c;
        longint                      s;
        longint                      px;
        longint                      py;
        int                          i;
        coord_result_t               res;

        // keep the configured angle precision, fold the left half plane
        a = (turn >> (ept_pkg::ANGLE_W - ept_pkg::ANGLE_BITS))
            << (ept_pkg::ANGLE_W - ept_pkg::ANGLE_BITS);
        flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (flip)
            a = a - 32'h8000_0000;

        // rotation-mode cordic with floor shifts
        x = longint'(ept_pkg::GAIN_Q30);
        y = 0;
        z = longint'(signed'(a));
        for (i = 0; i < ept_pkg::CORDIC_STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'({32'd0, ept_pkg::ATAN_TURNS[i]});
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'({32'd0, ept_pkg::ATAN_TURNS[i]});
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clamp_unit(x);
        s = clamp_unit(y);

        // scale by the radii, add the center for a point
        if (kind == REQ_TANGENT)
        begin
            px = -scale_radius(semi_x, s);
            py = scale_radius(semi_y, c);
        end
        else
        begin
            px = scale_radius(semi_x, c) + longint'(ctr_x);
            py = scale_radius(semi_y, s) + longint'(ctr_y);
        end

        ovf   = 1'b0;
        res.x = clip_coord(px, ovf);
        res.y = clip_coord(py, ovf);
        res.ovf = ovf;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        coord_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_POINT;
            angle    <= '0;
            send_gap <= 0;
        end
        else
        begin
            // predict on every accepted transfer
            if (in_valid && in_ready)
                coords_due.push_back(predict_coords(req_kind_t'(req_type), angle));

            // present the next request once the current one is gone
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (angle_reqs.size() != 0)
                begin
                    nxt = angle_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= nxt.kind;
                    angle    <= nxt.turn;
                    send_gap <= idle_on ? $urandom_range(0, 3) : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        coord_result_t due;
        int            w;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_wait  <= 0;
            hold_left  <= 0;
            recv_count <= 0;
        end
        else
        begin
            // check the transfer against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (coords_due.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with nothing due: x=%0d y=%0d ovf=%b",
                                              recv_count, coord_x, coord_y, overflow));
                end
                else
                begin
                    due = coords_due.pop_front();
                    if (coord_x !== due.x)
                        report_mismatch($sformatf("result %0d coord_x %0d, predicted %0d",
                                                  recv_count, coord_x, due.x));
                    if (coord_y !== due.y)
                        report_mismatch($sformatf("result %0d coord_y %0d, predicted %0d",
                                                  recv_count, coord_y, due.y));
                    if (overflow !== due.ovf)
                        report_mismatch($sformatf("result %0d overflow %b, predicted %b",
                                                  recv_count, overflow, due.ovf));
                end
                recv_count <= recv_count + 1;
            end

            // long hold-off at two points, short random stalls otherwise
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready &&
                     (recv_count == HOLD_AT_A || recv_count == HOLD_AT_B))
            begin
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                w = idle_on ? $urandom_range(0, 3) : 0;
                if (w != 0)
                begin
                    recv_wait <= w - 1;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
            else if (recv_wait != 0)
            begin
                recv_wait <= recv_wait - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t watchdog: no transfer for %0d cycles, %0d results due",
                     $time, QUIET_LIMIT, coords_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one register write, shadow updated on the transfer
    task automatic write_reg(input logic [ept_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ept_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            ept_pkg::REG_RADIUS_X: semi_x = val;
            ept_pkg::REG_RADIUS_Y: semi_y = val;
            ept_pkg::REG_CENTER_X: ctr_x  = val;
            ept_pkg::REG_CENTER_Y: ctr_y  = val;
            default: ;
        endcase
    endtask

    task automatic queue_req(input req_kind_t kind,
                             input logic [ept_pkg::ANGLE_W-1:0] turn);
        coord_req_t r;
        r.kind = kind;
        r.turn = turn;
        angle_reqs.push_back(r);
    endtask

    // wait until every request is sent and every result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (angle_reqs.size() != 0 || in_valid || coords_due.size() != 0);
    endtask

    // angles biased toward quadrant boundaries
    function automatic logic [ept_pkg::ANGLE_W-1:0] draw_angle();
        logic [1:0]                  quad;
        logic [ept_pkg::ANGLE_W-1:0] base;
        quad = $urandom_range(0, 3);
        base = {quad, 30'd0};
        case ($urandom_range(0, 3))
            0: return base + $urandom_range(0, 64) - 32'd32;
            1: return base - ($urandom & 32'h0000_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ept_pkg::CFG_DATA_W-1:0] draw_radius();
        if ($urandom_range(0, 1) != 0)
            return $urandom;
        return $urandom_range(1, 32'h00FF_FFFF);
    endfunction

    task automatic run_phase(input int n_items, input logic idle);
        int n;
        @(negedge clk);
        idle_on = idle;
        for (n = 0; n < n_items; n++)
            queue_req(req_kind_t'($urandom_range(0, 1)), draw_angle());
        wait_drained();
    endtask

    // stimulus sequence
    initial
    begin : stimulus
        logic [ept_pkg::ANGLE_W-1:0] corner_angles [12];
        int                          k;

        semi_x = ept_pkg::RADIUS_RESET;
        semi_y = ept_pkg::RADIUS_RESET;
        ctr_x  = ept_pkg::CENTER_RESET;
        ctr_y  = ept_pkg::CENTER_RESET;
        corner_angles = '{32'h0000_0000, 32'h0000_0001, 32'h2000_0000, 32'h3FFF_FFFF,
                          32'h4000_0000, 32'h4000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'hBFFF_FFFF, 32'hC000_0000, 32'hC000_0001, 32'hFFFF_FFFF};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // quadrant boundaries and wrap points at reset geometry
        @(negedge clk);
        idle_on = 1'b1;
        for (k = 0; k < 12; k++)
        begin
            queue_req(REQ_POINT, corner_angles[k]);
            queue_req(REQ_TANGENT, corner_angles[k]);
        end
        wait_drained();

        // largest radii with centers at both ends, saturating
        write_reg(ept_pkg::REG_RADIUS_X, 32'hFFFF_FFFF);
        write_reg(ept_pkg::REG_RADIUS_Y, 32'hFFFF_FFFF);
        write_reg(ept_pkg::REG_CENTER_X, 32'h7FFF_FFFF);
        write_reg(ept_pkg::REG_CENTER_Y, 32'h8000_0000);
        run_phase(150, 1'b0);

        // smallest radii, centers swapped
        write_reg(ept_pkg::REG_RADIUS_X, 32'd1);
        write_reg(ept_pkg::REG_RADIUS_Y, 32'd1);
        write_reg(ept_pkg::REG_CENTER_X, 32'h8000_0000);
        write_reg(ept_pkg::REG_CENTER_Y, 32'h7FFF_FFFF);
        run_phase(150, 1'b1);

        // zero radius gives a bare center
        write_reg(ept_pkg::REG_RADIUS_X, 32'd0);
        write_reg(ept_pkg::REG_RADIUS_Y, 32'd0);
        write_reg(ept_pkg::REG_CENTER_X, $urandom);
        write_reg(ept_pkg::REG_CENTER_Y, $urandom);
        run_phase(100, 1'b1);

        // ordinary ellipse, then writes to unused indexes must not disturb it
        write_reg(ept_pkg::REG_RADIUS_X, 32'd100 << 16);
        write_reg(ept_pkg::REG_RADIUS_Y, 32'd50 << 16);
        write_reg(ept_pkg::REG_CENTER_X, -(32'sd10 <<< 16));
        write_reg(ept_pkg::REG_CENTER_Y, 32'd20 << 16);
        for (k = 4; k < 16; k++)
            write_reg(k[ept_pkg::CFG_INDEX_W-1:0], $urandom);
        run_phase(250, 1'b1);

        // random geometry, idling on and off
        for (k = 0; k < 5; k++)
        begin
            write_reg(ept_pkg::REG_RADIUS_X, draw_radius());
            write_reg(ept_pkg::REG_RADIUS_Y, draw_radius());
            write_reg(ept_pkg::REG_CENTER_X, $urandom);
            write_reg(ept_pkg::REG_CENTER_Y, $urandom);
            run_phase(200, k[0] == 1'b0);
        end

        // catch any late stray result
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
